// ----- src/assert_macros.svh -----
// assert_macros.svh
// Shared assertion macros for the base64 decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define B64D_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/b64d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int TOTAL_W  = 24;
  localparam int MAX_RES  = 5;
  localparam int NRES_W   = 3;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PAD   = 8'h3D;

  typedef struct packed {
    logic       is_sym;
    logic       is_pad;
    logic [5:0] val;
  } b64d_sym_t;

  // One batch of results caused by a single input transfer.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [NRES_W-1:0]       nres;
    logic                    bval;
    logic                    last;
    logic [TOTAL_W-1:0]      total;
  } b64d_job_t;

  function automatic b64d_sym_t b64d_classify(input logic [7:0] c);
    b64d_sym_t s;
    s = '0;
    priority if (c >= CH_UP_A && c <= CH_UP_Z) begin
      s.is_sym = 1'b1;
      s.val    = 6'(c - CH_UP_A);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      s.is_sym = 1'b1;
      s.val    = 6'(c - CH_LO_A + 8'd26);
    end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      s.is_sym = 1'b1;
      s.val    = 6'(c - CH_DIG_0 + 8'd52);
    end else if (c == CH_PLUS) begin
      s.is_sym = 1'b1;
      s.val    = 6'd62;
    end else if (c == CH_SLASH) begin
      s.is_sym = 1'b1;
      s.val    = 6'd63;
    end else if (c == CH_PAD) begin
      s.is_pad = 1'b1;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- src/b64d_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// b64d_front
// Classifies characters, assembles sextet groups, holds back the two newest
// bytes and issues one result batch per transfer that produces output.
// ----------------------------------------------------------------------------
module b64d_front #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_char_valid,
  input  wire logic [7:0]          in_char_code,
  input  wire logic                in_end_of_text,
  output logic                     job_valid,
  input  wire logic                job_full,
  output b64d_pkg::b64d_job_t      job
);
  import b64d_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam int EXT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

  logic [17:0]            accum_r, accum_nxt;
  logic [1:0]             scnt_r, scnt_nxt;
  logic [1:0]             pad_r, pad_nxt;
  logic [1:0][7:0]        held_r, held_nxt;
  logic [1:0]             hcnt_r, hcnt_nxt;
  logic [COUNT_WIDTH-1:0] tot_r, tot_nxt;

  b64d_sym_t              sym;
  logic                   take;
  logic                   grp_done;
  logic [5:0]             v;
  logic [23:0]            w;
  logic [MAX_RES-1:0][7:0] q;
  logic [NRES_W-1:0]      base, qlen, emit_nl, emit_l;
  logic [1:0]             keep, tail, drop;
  logic [COUNT_WIDTH:0]   tot_sum;
  logic [COUNT_WIDTH-1:0] tot_rep;
  logic [EXT_W-1:0]       tot_ext;
  logic                   accept;

  assign in_stall = job_full;
  assign accept   = in_valid && !job_full;

  always_comb begin
    sym      = b64d_classify(in_char_code);
    take     = in_char_valid && (sym.is_sym || sym.is_pad);
    v        = sym.is_pad ? 6'd0 : sym.val;
    grp_done = take && (scnt_r == 2'd3);
    w        = {accum_r, v};

    pad_nxt = pad_r;
    if (take && sym.is_pad && pad_r < 2'd2) begin
      pad_nxt = pad_r + 2'd1;
    end

    accum_nxt = accum_r;
    scnt_nxt  = scnt_r;
    if (take) begin
      if (grp_done) begin
        accum_nxt = '0;
        scnt_nxt  = '0;
      end else begin
        accum_nxt = {accum_r[11:0], v};
        scnt_nxt  = scnt_r + 2'd1;
      end
    end

    tot_sum = {1'b0, tot_r} + (COUNT_WIDTH+1)'(3);
    tot_nxt = tot_r;
    if (grp_done) begin
      tot_nxt = (tot_sum >= {1'b0, CNT_MAX}) ? CNT_MAX : tot_sum[COUNT_WIDTH-1:0];
    end

    q = '0;
    unique case (hcnt_r)
      2'd1: begin
        q[0] = held_r[0];
        base = 3'd1;
      end
      2'd2: begin
        q[0] = held_r[0];
        q[1] = held_r[1];
        base = 3'd2;
      end
      default: base = 3'd0;
    endcase
    if (grp_done) begin
      q[base]              = w[23:16];
      q[NRES_W'(base + 1)] = w[15:8];
      q[NRES_W'(base + 2)] = w[7:0];
      qlen                 = base + 3'd3;
    end else begin
      qlen = base;
    end

    emit_nl = (qlen > 3'd2) ? qlen - 3'd2 : 3'd0;
    keep    = (qlen > 3'd2) ? 2'd2 : qlen[1:0];
    held_nxt[0] = (keep > 2'd0) ? q[emit_nl] : 8'd0;
    held_nxt[1] = (keep > 2'd1) ? q[NRES_W'(emit_nl + 1)] : 8'd0;
    hcnt_nxt    = keep;

    tail   = keep;
    drop   = (pad_nxt > tail) ? tail : pad_nxt;
    emit_l = qlen - {1'b0, drop};

    if (tot_nxt == CNT_MAX) begin
      tot_rep = CNT_MAX;
    end else if (tot_nxt > COUNT_WIDTH'(pad_nxt)) begin
      tot_rep = tot_nxt - COUNT_WIDTH'(pad_nxt);
    end else begin
      tot_rep = '0;
    end
    tot_ext = EXT_W'(tot_rep);

    job       = '0;
    job.bytes = q;
    if (in_end_of_text) begin
      job.last  = 1'b1;
      job.total = tot_ext[TOTAL_W-1:0];
      job.bval  = (emit_l != 3'd0);
      job.nres  = (emit_l != 3'd0) ? emit_l : 3'd1;
    end else begin
      job.bval = 1'b1;
      job.nres = emit_nl;
    end
  end

  assign job_valid = in_valid && (in_end_of_text || emit_nl != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      scnt_r  <= '0;
      pad_r   <= '0;
      held_r  <= '0;
      hcnt_r  <= '0;
      tot_r   <= '0;
    end else if (accept) begin
      if (in_end_of_text) begin
        accum_r <= '0;
        scnt_r  <= '0;
        pad_r   <= '0;
        held_r  <= '0;
        hcnt_r  <= '0;
        tot_r   <= '0;
      end else begin
        accum_r <= accum_nxt;
        scnt_r  <= scnt_nxt;
        pad_r   <= pad_nxt;
        held_r  <= held_nxt;
        hcnt_r  <= hcnt_nxt;
        tot_r   <= tot_nxt;
      end
    end
  end

  `B64D_ASSERT(a_front_nres, clk, rst_n, job_valid |-> (job.nres != 3'd0 && job.nres <= 3'd5), "batch size out of range")
  `B64D_ASSERT_NEXT(a_front_clear, clk, rst_n, accept && in_end_of_text, scnt_r == 2'd0 && pad_r == 2'd0 && hcnt_r == 2'd0, "state not cleared after end of text")

endmodule
`default_nettype wire

// ----- src/b64d_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// b64d_fifo
// Short queue of result batches between the front and the back.
// ----------------------------------------------------------------------------
module b64d_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                full,
  input  wire b64d_pkg::b64d_job_t wr_job,
  output logic                rd_valid,
  input  wire logic           rd_stall,
  output b64d_pkg::b64d_job_t rd_job
);
  import b64d_pkg::*;

  b64d_job_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QPTR_W:0]     cnt_r;
  logic                push, pop;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rptr_r];
  assign push     = wr_valid && !full;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `B64D_ASSERT(a_fifo_bound, clk, rst_n, cnt_r <= (QPTR_W+1)'(QDEPTH), "queue count overflow")

endmodule
`default_nettype wire

// ----- src/b64d_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// b64d_back
// Walks each batch one result per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module b64d_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          job_valid,
  output logic                               job_stall,
  input  wire b64d_pkg::b64d_job_t           job,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_byte_valid,
  output logic [7:0]                         out_byte,
  output logic                               out_final_res,
  output logic [b64d_pkg::TOTAL_W-1:0]       out_total_bytes
);
  import b64d_pkg::*;

  b64d_job_t           cur_r;
  logic                busy_r;
  logic [NRES_W-1:0]   idx_r;
  logic                ovld_r, obv_r, ofin_r;
  logic [7:0]          obyte_r;
  logic [TOTAL_W-1:0]  otot_r;
  logic                slot_free, fire, done, load, fin;

  assign slot_free = !ovld_r || !out_stall;
  assign fire      = busy_r && slot_free;
  assign done      = fire && (idx_r == cur_r.nres - 3'd1);
  assign job_stall = busy_r && !done;
  assign load      = job_valid && !job_stall;
  assign fin       = cur_r.last && (idx_r == cur_r.nres - 3'd1);

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= job;
    end
    if (fire) begin
      obv_r   <= cur_r.bval;
      obyte_r <= cur_r.bval ? cur_r.bytes[idx_r] : 8'd0;
      ofin_r  <= fin;
      otot_r  <= fin ? cur_r.total : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (fire) begin
        idx_r <= idx_r + 3'd1;
      end
      if (fire) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
    end
  end

  assign out_valid       = ovld_r;
  assign out_byte_valid  = obv_r;
  assign out_byte        = obyte_r;
  assign out_final_res   = ofin_r;
  assign out_total_bytes = otot_r;

  `B64D_ASSERT(a_back_idx, clk, rst_n, busy_r |-> idx_r < cur_r.nres, "result index past batch")
  `B64D_ASSERT(a_back_total, clk, rst_n, (ovld_r && !ofin_r) |-> (otot_r == '0),
               "total on non-final result")

endmodule
`default_nettype wire

// ----- src/base64_stream_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 text decoder: one character per transfer in, decoded bytes out.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   char_valid, char_code, end_of_text
//   out_     out  out_valid/out_stall byte_valid, out_byte, final_res, total_bytes
//
// One character is taken per cycle while in_stall is low; a group of four gives three bytes.
// The back end emits one result per cycle while out_stall is low, up to five for an end transfer.
// Results pass through the batch queue, the back end's batch register and the output register.
// A four-entry batch queue lets input run on while output is stalled.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_char_valid,
  input  wire logic [7:0]                    in_char_code,
  input  wire logic                          in_end_of_text,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_byte_valid,
  output logic [7:0]                         out_byte,
  output logic                               out_final_res,
  output logic [b64d_pkg::TOTAL_W-1:0]       out_total_bytes
);
  import b64d_pkg::*;

  b64d_job_t f_job, q_job;
  logic      f_valid, q_full, q_valid, q_stall;

  b64d_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_valid  (in_char_valid),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .job_valid      (f_valid),
    .job_full       (q_full),
    .job            (f_job)
  );

  b64d_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .full     (q_full),
    .wr_job   (f_job),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_job   (q_job)
  );

  b64d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (q_valid),
    .job_stall       (q_stall),
    .job             (q_job),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_valid  (out_byte_valid),
    .out_byte        (out_byte),
    .out_final_res   (out_final_res),
    .out_total_bytes (out_total_bytes)
  );

endmodule
`default_nettype wire
